// File: hdl/sbc_pkg.sv
package sbc_pkg;

	// Geometry of the cache and its per-entry state.
	localparam int ENTRIES = 64;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int TAG_W = 32;
	localparam int RDR_W = 8;
	localparam logic [RDR_W-1:0] MAX_READERS = 8'd255;

	// Command codes.
	localparam logic [2:0] CMD_ACQUIRE = 3'd0;
	localparam logic [2:0] CMD_RELEASE = 3'd1;
	localparam logic [2:0] CMD_LOAD    = 3'd2;
	localparam logic [2:0] CMD_ZERO    = 3'd3;
	localparam logic [2:0] CMD_MARK    = 3'd4;
	localparam logic [2:0] CMD_FLUSH   = 3'd5;

	// Result status codes.
	localparam logic [2:0] ST_DONE   = 3'd0;
	localparam logic [2:0] ST_WAIT   = 3'd1;
	localparam logic [2:0] ST_NOFREE = 3'd2;
	localparam logic [2:0] ST_DISK   = 3'd3;
	localparam logic [2:0] ST_MISUSE = 3'd4;

	// Disk operation codes.
	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_ZERO  = 2'd3;

	// Source of the result sector field.
	localparam logic [1:0] SEL_ZERO = 2'd0;
	localparam logic [1:0] SEL_SEC  = 2'd1;
	localparam logic [1:0] SEL_TAG  = 2'd2;

	// Reader count update.
	localparam logic [1:0] RDR_ZERO = 2'd0;
	localparam logic [1:0] RDR_ONE  = 2'd1;
	localparam logic [1:0] RDR_INC  = 2'd2;
	localparam logic [1:0] RDR_DEC  = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             load_in;
		logic             scan_clr;
		logic             scan;
		logic             rd_tag;
		logic             rd_rdr;
		logic [IDX_W-1:0] addr;
		logic             emit;
		logic [2:0]       o_status;
		logic [IDX_W-1:0] o_slot;
		logic [1:0]       o_op;
		logic [1:0]       o_sec_sel;
		logic             o_last;
		logic             alloc;
		logic             alloc_excl;
		logic             set_writer;
		logic             clr_writer;
		logic             rdr_we;
		logic [1:0]       rdr_sel;
		logic             set_valid;
		logic             set_dirty;
		logic             clr_dirty;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0]       command;
		logic             exclusive;
		logic [IDX_W-1:0] entry;
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic             free;
		logic [IDX_W-1:0] free_idx;
		logic             assigned;
		logic             valid;
		logic             dirty;
		logic             writer;
		logic             rdr_nz;
		logic             rdr_full;
		logic             vd_here;
		logic             more_after;
		logic             out_free;
	} dp_sts_t;

endpackage

// File: hdl/sbc_req_if.sv
interface sbc_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [31:0] sector;
	logic        exclusive;
	logic [5:0]  entry;

	modport source(output valid, command, sector, exclusive, entry, input ready);
	modport sink(input valid, command, sector, exclusive, entry, output ready);
endinterface

// File: hdl/sbc_rsp_if.sv
interface sbc_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [5:0]  slot;
	logic [1:0]  disk_op;
	logic [31:0] disk_sector;
	logic        last;

	modport source(output valid, status, slot, disk_op, disk_sector, last, input ready);
	modport sink(input valid, status, slot, disk_op, disk_sector, last, output ready);
endinterface

// File: hdl/sbc_datapath.sv
module sbc_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sbc_pkg::dp_cmd_t     cmd,
	output sbc_pkg::dp_sts_t     sts,
	input  logic [2:0]           command,
	input  logic [31:0]          sector,
	input  logic                 exclusive,
	input  logic [5:0]           entry,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           status,
	output logic [5:0]           slot,
	output logic [1:0]           disk_op,
	output logic [31:0]          disk_sector,
	output logic                 last
);
	import sbc_pkg::*;

	logic [2:0]             command_q;
	logic [TAG_W-1:0]       sector_q;
	logic                   exclusive_q;
	logic [IDX_W-1:0]       entry_q;
	logic [TAG_W-1:0]       tag_mem [ENTRIES];
	logic [RDR_W-1:0]       rdr_mem [ENTRIES];
	logic [TAG_W-1:0]       tag_rd_q;
	logic [RDR_W-1:0]       rdr_rd_q;
	logic [ENTRIES-1:0]     assigned_q;
	logic [ENTRIES-1:0]     valid_q;
	logic [ENTRIES-1:0]     dirty_q;
	logic [ENTRIES-1:0]     writer_q;
	logic [ENTRIES-1:0]     rdr_nz_q;
	logic                   scan_s1;
	logic [IDX_W-1:0]       addr_s1;
	logic                   hit_q;
	logic [IDX_W-1:0]       hit_idx_q;
	logic                   free_q;
	logic [IDX_W-1:0]       free_idx_q;
	logic                   out_valid_q;
	logic [2:0]             status_q;
	logic [IDX_W-1:0]       slot_q;
	logic [1:0]             disk_op_q;
	logic [TAG_W-1:0]       disk_sector_q;
	logic                   last_q;
	logic [RDR_W-1:0]       rdr_wdata;
	logic                   rdr_wnz;
	logic [ENTRIES-1:0]     vd_vec;
	logic                   out_free;

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			command_q   <= command;
			sector_q    <= sector;
			exclusive_q <= exclusive;
			entry_q     <= entry;
		end
	end

	// Reader count write data and its nonzero flag.
	always_comb begin
		rdr_wdata = '0;
		rdr_wnz   = 1'b0;
		case (cmd.rdr_sel)
			RDR_ZERO: begin
				rdr_wdata = '0;
				rdr_wnz   = 1'b0;
			end
			RDR_ONE: begin
				rdr_wdata = RDR_W'(1);
				rdr_wnz   = 1'b1;
			end
			RDR_INC: begin
				rdr_wdata = rdr_rd_q + RDR_W'(1);
				rdr_wnz   = 1'b1;
			end
			default: begin
				rdr_wdata = rdr_rd_q - RDR_W'(1);
				rdr_wnz   = (rdr_rd_q != RDR_W'(1));
			end
		endcase
	end

	// Tag and reader count memories, registered reads.
	always_ff @(posedge clk) begin
		if (cmd.alloc) begin
			tag_mem[cmd.addr] <= sector_q;
		end
		if (cmd.rd_tag) begin
			tag_rd_q <= tag_mem[cmd.addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rdr_we) begin
			rdr_mem[cmd.addr] <= rdr_wdata;
		end
		if (cmd.rd_rdr) begin
			rdr_rd_q <= rdr_mem[cmd.addr];
		end
	end

	// Per-entry flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			assigned_q <= '0;
			valid_q    <= '0;
			dirty_q    <= '0;
			writer_q   <= '0;
			rdr_nz_q   <= '0;
		end else begin
			if (cmd.alloc) begin
				assigned_q[cmd.addr] <= 1'b1;
				valid_q[cmd.addr]    <= 1'b0;
				dirty_q[cmd.addr]    <= 1'b0;
				writer_q[cmd.addr]   <= cmd.alloc_excl;
			end
			if (cmd.set_writer) begin
				writer_q[cmd.addr] <= 1'b1;
			end
			if (cmd.clr_writer) begin
				writer_q[cmd.addr] <= 1'b0;
			end
			if (cmd.rdr_we) begin
				rdr_nz_q[cmd.addr] <= rdr_wnz;
			end
			if (cmd.set_valid) begin
				valid_q[cmd.addr] <= 1'b1;
			end
			if (cmd.set_dirty) begin
				dirty_q[cmd.addr] <= 1'b1;
			end
			if (cmd.clr_dirty) begin
				dirty_q[cmd.addr] <= 1'b0;
			end
		end
	end

	// Lookup scan: free check on the current entry, tag compare on it in the following cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_s1    <= 1'b0;
			addr_s1    <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
		end else begin
			scan_s1 <= cmd.scan;
			addr_s1 <= cmd.addr;
			if (cmd.scan_clr) begin
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else begin
				if (scan_s1 && !hit_q && assigned_q[addr_s1] && tag_rd_q == sector_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= addr_s1;
				end
				if (cmd.scan && !free_q && !rdr_nz_q[cmd.addr] && !writer_q[cmd.addr]) begin
					free_q     <= 1'b1;
					free_idx_q <= cmd.addr;
				end
			end
		end
	end

	// Result register.
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q  <= cmd.o_status;
			slot_q    <= cmd.o_slot;
			disk_op_q <= cmd.o_op;
			last_q    <= cmd.o_last;
			case (cmd.o_sec_sel)
				SEL_SEC: disk_sector_q <= sector_q;
				SEL_TAG: disk_sector_q <= tag_rd_q;
				default: disk_sector_q <= '0;
			endcase
		end
	end

	// Dirty entries beyond the addressed one, for the flush end marker.
	assign vd_vec = valid_q & dirty_q;

	always_comb begin
		sts.command    = command_q;
		sts.exclusive  = exclusive_q;
		sts.entry      = entry_q;
		sts.hit        = hit_q;
		sts.hit_idx    = hit_idx_q;
		sts.free       = free_q;
		sts.free_idx   = free_idx_q;
		sts.assigned   = assigned_q[cmd.addr];
		sts.valid      = valid_q[cmd.addr];
		sts.dirty      = dirty_q[cmd.addr];
		sts.writer     = writer_q[cmd.addr];
		sts.rdr_nz     = rdr_nz_q[cmd.addr];
		sts.rdr_full   = (rdr_rd_q == MAX_READERS);
		sts.vd_here    = vd_vec[cmd.addr];
		sts.more_after = |(vd_vec & (({ENTRIES{1'b1}} << cmd.addr) << 1));
		sts.out_free   = out_free;
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign slot        = slot_q;
	assign disk_op     = disk_op_q;
	assign disk_sector = disk_sector_q;
	assign last        = last_q;

endmodule

// File: hdl/sbc_ctrl.sv
module sbc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  sbc_pkg::dp_sts_t sts,
	output sbc_pkg::dp_cmd_t cmd
);
	import sbc_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DISPATCH = 4'd1;
	localparam logic [3:0] S_SCAN     = 4'd2;
	localparam logic [3:0] S_SCAN_END = 4'd3;
	localparam logic [3:0] S_DECIDE   = 4'd4;
	localparam logic [3:0] S_GRANT    = 4'd5;
	localparam logic [3:0] S_WB       = 4'd6;
	localparam logic [3:0] S_FRESH    = 4'd7;
	localparam logic [3:0] S_REL      = 4'd8;
	localparam logic [3:0] S_ONE      = 4'd9;
	localparam logic [3:0] S_FL_FIND  = 4'd10;
	localparam logic [3:0] S_FL_EMIT  = 4'd11;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

	logic [3:0]       state_q;
	logic [3:0]       state_d;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_d;
	logic             wait_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	// Lock conflict for the hit entry.
	assign wait_c = sts.exclusive ? (sts.rdr_nz || sts.writer)
	                              : (sts.writer || sts.rdr_full);

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				cmd.addr = sts.entry;
				if (sts.command == CMD_ACQUIRE) begin
					cmd.scan_clr = 1'b1;
					idx_d        = '0;
					state_d      = S_SCAN;
				end else if (sts.command == CMD_FLUSH) begin
					idx_d   = '0;
					state_d = S_FL_FIND;
				end else if (sts.command > CMD_FLUSH) begin
					if (sts.out_free) begin
						cmd.emit     = 1'b1;
						cmd.o_status = ST_MISUSE;
						cmd.o_last   = 1'b1;
						state_d      = S_IDLE;
					end
				end else if (!sts.assigned) begin
					if (sts.out_free) begin
						cmd.emit     = 1'b1;
						cmd.o_status = ST_MISUSE;
						cmd.o_slot   = sts.entry;
						cmd.o_last   = 1'b1;
						state_d      = S_IDLE;
					end
				end else if (sts.command == CMD_RELEASE) begin
					cmd.rd_rdr = 1'b1;
					state_d    = S_REL;
				end else begin
					cmd.rd_tag = 1'b1;
					state_d    = S_ONE;
				end
			end
			S_SCAN: begin
				cmd.addr   = idx_q;
				cmd.scan   = 1'b1;
				cmd.rd_tag = 1'b1;
				idx_d      = idx_q + IDX_W'(1);
				if (idx_q == IDX_LAST) begin
					state_d = S_SCAN_END;
				end
			end
			S_SCAN_END: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.hit) begin
					cmd.addr   = sts.hit_idx;
					cmd.rd_rdr = 1'b1;
					state_d    = S_GRANT;
				end else if (!sts.free) begin
					if (sts.out_free) begin
						cmd.emit     = 1'b1;
						cmd.o_status = ST_NOFREE;
						cmd.o_last   = 1'b1;
						state_d      = S_IDLE;
					end
				end else begin
					cmd.addr   = sts.free_idx;
					cmd.rd_tag = 1'b1;
					state_d    = sts.dirty ? S_WB : S_FRESH;
				end
			end
			S_GRANT: begin
				cmd.addr = sts.hit_idx;
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.o_status  = wait_c ? ST_WAIT : ST_DONE;
					cmd.o_slot    = sts.hit_idx;
					cmd.o_sec_sel = SEL_SEC;
					cmd.o_last    = 1'b1;
					if (!wait_c) begin
						cmd.set_writer = sts.exclusive;
						cmd.rdr_we     = !sts.exclusive;
						cmd.rdr_sel    = RDR_INC;
					end
					state_d = S_IDLE;
				end
			end
			S_WB: begin
				cmd.addr = sts.free_idx;
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.o_status  = ST_DISK;
					cmd.o_slot    = sts.free_idx;
					cmd.o_op      = OP_WRITE;
					cmd.o_sec_sel = SEL_TAG;
					state_d       = S_FRESH;
				end
			end
			S_FRESH: begin
				// A freshly claimed entry is always granted.
				cmd.addr = sts.free_idx;
				if (sts.out_free) begin
					cmd.emit       = 1'b1;
					cmd.o_status   = ST_DONE;
					cmd.o_slot     = sts.free_idx;
					cmd.o_sec_sel  = SEL_SEC;
					cmd.o_last     = 1'b1;
					cmd.alloc      = 1'b1;
					cmd.alloc_excl = sts.exclusive;
					cmd.rdr_we     = 1'b1;
					cmd.rdr_sel    = sts.exclusive ? RDR_ZERO : RDR_ONE;
					state_d        = S_IDLE;
				end
			end
			S_REL: begin
				cmd.addr = sts.entry;
				if (sts.out_free) begin
					cmd.emit   = 1'b1;
					cmd.o_slot = sts.entry;
					cmd.o_last = 1'b1;
					if (sts.writer) begin
						cmd.o_status   = ST_DONE;
						cmd.clr_writer = 1'b1;
					end else if (sts.rdr_nz) begin
						cmd.o_status = ST_DONE;
						cmd.rdr_we   = 1'b1;
						cmd.rdr_sel  = RDR_DEC;
					end else begin
						cmd.o_status = ST_MISUSE;
					end
					state_d = S_IDLE;
				end
			end
			S_ONE: begin
				cmd.addr = sts.entry;
				if (sts.out_free) begin
					cmd.emit   = 1'b1;
					cmd.o_slot = sts.entry;
					cmd.o_last = 1'b1;
					case (sts.command)
						CMD_LOAD: begin
							if (!sts.valid) begin
								cmd.o_status  = ST_DISK;
								cmd.o_op      = OP_READ;
								cmd.o_sec_sel = SEL_TAG;
								cmd.set_valid = 1'b1;
							end else begin
								cmd.o_status = ST_DONE;
							end
						end
						CMD_ZERO: begin
							cmd.o_status  = ST_DISK;
							cmd.o_op      = OP_ZERO;
							cmd.o_sec_sel = SEL_TAG;
							cmd.set_valid = 1'b1;
							cmd.set_dirty = 1'b1;
						end
						default: begin
							if (!sts.valid) begin
								cmd.o_status = ST_MISUSE;
							end else begin
								cmd.o_status  = ST_DISK;
								cmd.o_op      = OP_WRITE;
								cmd.o_sec_sel = SEL_TAG;
								cmd.clr_dirty = 1'b1;
							end
						end
					endcase
					state_d = S_IDLE;
				end
			end
			S_FL_FIND: begin
				cmd.addr = idx_q;
				if (sts.vd_here) begin
					cmd.rd_tag = 1'b1;
					state_d    = S_FL_EMIT;
				end else if (idx_q == IDX_LAST) begin
					// Reached only when nothing was dirty.
					if (sts.out_free) begin
						cmd.emit     = 1'b1;
						cmd.o_status = ST_DONE;
						cmd.o_last   = 1'b1;
						state_d      = S_IDLE;
					end
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			S_FL_EMIT: begin
				cmd.addr = idx_q;
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.o_status  = ST_DISK;
					cmd.o_slot    = idx_q;
					cmd.o_op      = OP_WRITE;
					cmd.o_sec_sel = SEL_TAG;
					cmd.o_last    = !sts.more_after;
					cmd.clr_dirty = 1'b1;
					if (sts.more_after) begin
						idx_d   = idx_q + IDX_W'(1);
						state_d = S_FL_FIND;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: hdl/sector_buffer_cache_controller_top.sv
// Acquire: a 64-entry tag scan, one entry per cycle through the tag memory port, then one result,
// preceded by a write-back result when the claimed entry is dirty.
// Release, load, zero fill, mark (write-back of a valid entry) and bad commands give one result each.
// Flush: one pass over all entries.
// One request is processed at a time; results leave through an output register.
// Reset clears all entry flags at once; tags and reader counts need no clearing.
module sector_buffer_cache_controller_top (
	input logic      clk,
	input logic      arst_n,
	sbc_req_if.sink  req,
	sbc_rsp_if.source rsp
);
	import sbc_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencing of each request.
	sbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Entry state, lookup and result register.
	sbc_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.command     (req.command),
		.sector      (req.sector),
		.exclusive   (req.exclusive),
		.entry       (req.entry),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.status      (rsp.status),
		.slot        (rsp.slot),
		.disk_op     (rsp.disk_op),
		.disk_sector (rsp.disk_sector),
		.last        (rsp.last)
	);

endmodule

// File: hdl/sbc_checker.sv
module sbc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  status,
	input logic [1:0]  disk_op,
	input logic [31:0] disk_sector
);
	import sbc_pkg::*;

	// A stalled result holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(disk_sector))
		else $error("result changed while stalled");

	// One request at a time: ready drops after an accepted request.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in progress");

	// Disk operations appear exactly on disk request results.
	a_disk_op: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((status == ST_DISK) == (disk_op != OP_NONE)))
		else $error("disk operation inconsistent with status");

	// Only defined status codes are returned.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == ST_DONE || status == ST_WAIT || status == ST_NOFREE ||
			status == ST_DISK || status == ST_MISUSE))
		else $error("undefined status code");

endmodule

bind sector_buffer_cache_controller_top sbc_checker u_sbc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.disk_op     (rsp.disk_op),
	.disk_sector (rsp.disk_sector)
);
